// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, off during reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `ASSERT_AT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/lsc_pkg.sv -----
// types, constants and helpers of the line segment clipper
package lsc_pkg;

  localparam int COORD_W       = 24;
  localparam int CFG_W         = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MAX_STEPS_DEF = 4;
  localparam int STEP_W        = 4;
  localparam int OUT_STEP_W    = 3;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int NUM_W         = 2 * DIFF_W;
  localparam int QUOT_W        = 26;
  localparam int SUM_W         = QUOT_W + 2;
  localparam int IN_DATA_W     = 4 * COORD_W;
  localparam int OUT_DATA_W    = ((4 * COORD_W + OUT_STEP_W + 7) / 8) * 8;
  localparam int CFG_IDX_W     = 2;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

  localparam logic signed [CFG_W-1:0] RST_LEFT   = 16'sd0;
  localparam logic signed [CFG_W-1:0] RST_BOTTOM = 16'sd0;
  localparam logic signed [CFG_W-1:0] RST_RIGHT  = 16'sd639;
  localparam logic signed [CFG_W-1:0] RST_TOP    = 16'sd479;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } win_t;

  typedef struct packed {
    coord_t             x0;
    coord_t             y0;
    coord_t             x1;
    coord_t             y1;
    logic [3:0]         c0;
    logic [3:0]         c1;
    logic [STEP_W-1:0]  steps;
    logic               done;
    logic               accept;
  } seg_t;

  typedef struct packed {
    logic   active;
    logic   ymode;
    logic   sel_end;
    coord_t p0;
    coord_t edge_q;
  } op_t;

  typedef struct packed {
    seg_t seg;
    op_t  op;
  } ctx_t;

  function automatic coord_t sat_coord(input logic signed [31:0] v);
    coord_t r;
    if (v > 32'sd8388607) begin
      r = coord_t'(24'sh7fffff);
    end else if (v < -32'sd8388608) begin
      r = coord_t'(24'sh800000);
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

  function automatic logic [3:0] outcode(input coord_t x, input coord_t y, input win_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < w.left) begin
      c = c | OC_LEFT;
    end else if (x > w.right) begin
      c = c | OC_RIGHT;
    end
    if (y < w.bottom) begin
      c = c | OC_BOTTOM;
    end else if (y > w.top) begin
      c = c | OC_TOP;
    end
    return c;
  endfunction

endpackage

// ----- rtl/line_segment_clipper_core.sv -----
// Cohen-Sutherland line clipper top level. A segment enters on every cycle
// that s_tready is high; its result leaves through the head register, the
// clip steps and the output register. Each clip step is a chain of
// registers: edge select, a 25 by 25 multiply, a restoring divider giving
// one quotient bit per stage, and the endpoint update. The whole pipeline
// holds while a result waits on m_tready. Window registers may only be
// written while no segment is in flight.
`include "assert_macros.svh"

module line_segment_clipper_core #(
  parameter int FRAC_BITS      = lsc_pkg::FRAC_BITS_DEF,
  parameter int MAX_CLIP_STEPS = lsc_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [lsc_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y, clip_steps, zero pad
  output logic [lsc_pkg::OUT_DATA_W-1:0]      m_tdata,
  // visible
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsc_pkg::CFG_W-1:0]           cfg_data
);
  import lsc_pkg::*;

  logic signed [CFG_W-1:0] win_left, win_bottom, win_right, win_top;
  win_t                    win;
  logic                    en;

  logic                    head_vld;
  seg_t                    head_seg;
  logic                    chain_vld [MAX_CLIP_STEPS+1];
  seg_t                    chain_seg [MAX_CLIP_STEPS+1];
  seg_t                    entry_seg;
  seg_t                    fin;
  logic                    fin_accept;

  logic                    out_vld;
  logic                    out_vis;
  coord_t                  out_x0, out_y0, out_x1, out_y1;
  logic [OUT_STEP_W-1:0]   out_steps;

  function automatic coord_t scale_edge(input logic signed [CFG_W-1:0] r);
    logic signed [31:0] s;
    s = 32'(r) <<< FRAC_BITS;
    return sat_coord(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= RST_LEFT;
      win_bottom <= RST_BOTTOM;
      win_right  <= RST_RIGHT;
      win_top    <= RST_TOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   win_left   <= cfg_data;
        REG_BOTTOM: win_bottom <= cfg_data;
        REG_RIGHT:  win_right  <= cfg_data;
        REG_TOP:    win_top    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign win.left   = scale_edge(win_left);
  assign win.bottom = scale_edge(win_bottom);
  assign win.right  = scale_edge(win_right);
  assign win.top    = scale_edge(win_top);

  assign en       = !out_vld || m_tready;
  assign s_tready = en;

  always_comb begin
    entry_seg        = '0;
    entry_seg.x0     = coord_t'(s_tdata[COORD_W-1:0]);
    entry_seg.y0     = coord_t'(s_tdata[2*COORD_W-1:COORD_W]);
    entry_seg.x1     = coord_t'(s_tdata[3*COORD_W-1:2*COORD_W]);
    entry_seg.y1     = coord_t'(s_tdata[4*COORD_W-1:3*COORD_W]);
    entry_seg.c0     = outcode(entry_seg.x0, entry_seg.y0, win);
    entry_seg.c1     = outcode(entry_seg.x1, entry_seg.y1, win);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
    end else if (en) begin
      head_vld <= s_tvalid;
    end
    if (en) begin
      head_seg <= entry_seg;
    end
  end

  assign chain_vld[0] = head_vld;
  assign chain_seg[0] = head_seg;

  for (genvar i = 0; i < MAX_CLIP_STEPS; i++) begin : g_step
    lsc_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .win     (win),
      .in_vld  (chain_vld[i]),
      .in_seg  (chain_seg[i]),
      .out_vld (chain_vld[i+1]),
      .out_seg (chain_seg[i+1])
    );
  end

  // unresolved after the last step counts as rejected unless both outcodes are zero
  assign fin        = chain_seg[MAX_CLIP_STEPS];
  assign fin_accept = fin.done ? fin.accept : ((fin.c0 | fin.c1) == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= chain_vld[MAX_CLIP_STEPS];
    end
    if (en) begin
      out_vis   <= fin_accept;
      out_x0    <= fin_accept ? fin.x0 : '0;
      out_y0    <= fin_accept ? fin.y0 : '0;
      out_x1    <= fin_accept ? fin.x1 : '0;
      out_y1    <= fin_accept ? fin.y1 : '0;
      out_steps <= (fin.steps > STEP_W'(7)) ? OUT_STEP_W'(7) : OUT_STEP_W'(fin.steps);
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_vis;
  assign m_tdata  = OUT_DATA_W'({out_steps, out_y1, out_x1, out_y0, out_x0});

  `ASSERT_IMPLIES(a_reject_zero, m_tvalid && !m_tuser, m_tdata[4*COORD_W-1:0] == '0, "rejected item carries coordinates")
  `ASSERT_IMPLIES(a_steps_max, m_tvalid, int'(out_steps) <= MAX_CLIP_STEPS, "step count above limit")
  `ASSERT_IMPLIES(a_visible_codes, chain_vld[MAX_CLIP_STEPS] && fin.accept, (fin.c0 | fin.c1) == 4'd0, "accepted segment has outside endpoint")

endmodule

// ----- rtl/lsc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, clamped quotient
module lsc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  lsc_pkg::ctx_t                      in_ctx,
  input  logic signed [lsc_pkg::NUM_W-1:0]   in_num,
  input  logic signed [lsc_pkg::DIFF_W-1:0]  in_dq,
  output logic                               out_vld,
  output lsc_pkg::ctx_t                      out_ctx,
  output logic signed [lsc_pkg::QUOT_W:0]    out_quot
);
  import lsc_pkg::*;

  localparam int CW = DIFF_W + QUOT_W;

  logic [NUM_W-1:0]  num_mag;
  logic [DIFF_W-1:0] dq_mag;

  // index 0 is the operand register, index s+1 holds the state after quotient bit s
  logic              vld  [QUOT_W+1];
  ctx_t              ctx  [QUOT_W+1];
  logic [QUOT_W-1:0] q    [QUOT_W+1];
  logic              neg  [QUOT_W+1];
  logic              ovf  [QUOT_W+1];
  logic              zero [QUOT_W+1];
  logic [CW-1:0]     rem  [QUOT_W];
  logic [DIFF_W-1:0] dqm  [QUOT_W];

  logic [QUOT_W-1:0] mag;

  assign num_mag = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
  assign dq_mag  = in_dq[DIFF_W-1] ? DIFF_W'(-in_dq) : DIFF_W'(in_dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QUOT_W; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_vld;
      for (int s = 0; s < QUOT_W; s++) begin
        vld[s+1] <= vld[s];
      end
    end
    if (en) begin
      ctx[0]  <= in_ctx;
      rem[0]  <= CW'(num_mag);
      dqm[0]  <= dq_mag;
      q[0]    <= '0;
      neg[0]  <= in_num[NUM_W-1] ^ in_dq[DIFF_W-1];
      zero[0] <= (dq_mag == '0);
      ovf[0]  <= (CW'(num_mag) >= (CW'(dq_mag) << QUOT_W));
      for (int s = 0; s < QUOT_W; s++) begin
        ctx[s+1]  <= ctx[s];
        neg[s+1]  <= neg[s];
        ovf[s+1]  <= ovf[s];
        zero[s+1] <= zero[s];
        if (rem[s] >= (CW'(dqm[s]) << (QUOT_W - 1 - s))) begin
          q[s+1] <= q[s] | (QUOT_W'(1) << (QUOT_W - 1 - s));
        end else begin
          q[s+1] <= q[s];
        end
      end
      for (int s = 0; s < QUOT_W - 1; s++) begin
        dqm[s+1] <= dqm[s];
        if (rem[s] >= (CW'(dqm[s]) << (QUOT_W - 1 - s))) begin
          rem[s+1] <= rem[s] - (CW'(dqm[s]) << (QUOT_W - 1 - s));
        end else begin
          rem[s+1] <= rem[s];
        end
      end
    end
  end

  always_comb begin
    if (zero[QUOT_W]) begin
      mag = '0;
    end else if (ovf[QUOT_W]) begin
      mag = '1;
    end else begin
      mag = q[QUOT_W];
    end
  end

  assign out_vld  = vld[QUOT_W];
  assign out_ctx  = ctx[QUOT_W];
  assign out_quot = neg[QUOT_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ----- rtl/lsc_step.sv -----
// one clipping step: decide, multiply, divide, move the endpoint
module lsc_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  lsc_pkg::win_t win,
  input  logic          in_vld,
  input  lsc_pkg::seg_t in_seg,
  output logic          out_vld,
  output lsc_pkg::seg_t out_seg
);
  import lsc_pkg::*;

  ctx_t                      a_ctx_next;
  logic signed [DIFF_W-1:0]  dp, dn, dq;
  logic [3:0]                co;
  coord_t                    p1, q0, q1;

  logic                      a_vld;
  ctx_t                      a_ctx;
  logic signed [DIFF_W-1:0]  a_dp, a_dn, a_dq;

  logic                      b_vld;
  ctx_t                      b_ctx;
  logic signed [NUM_W-1:0]   b_num;
  logic signed [DIFF_W-1:0]  b_dq;

  logic                      d_vld;
  ctx_t                      d_ctx;
  logic signed [QUOT_W:0]    d_quot;

  logic signed [SUM_W-1:0]   sum;
  coord_t                    v;
  seg_t                      seg_next;

  always_comb begin
    a_ctx_next         = '0;
    a_ctx_next.seg     = in_seg;
    co                 = (in_seg.c0 != 4'd0) ? in_seg.c0 : in_seg.c1;
    p1                 = in_seg.x1;
    q0                 = in_seg.y0;
    q1                 = in_seg.y1;
    if (!in_seg.done) begin
      if ((in_seg.c0 | in_seg.c1) == 4'd0) begin
        a_ctx_next.seg.done   = 1'b1;
        a_ctx_next.seg.accept = 1'b1;
      end else if ((in_seg.c0 & in_seg.c1) != 4'd0) begin
        a_ctx_next.seg.done   = 1'b1;
      end else begin
        a_ctx_next.op.active  = 1'b1;
      end
    end
    a_ctx_next.op.sel_end = (in_seg.c0 == 4'd0);
    if ((co & OC_TOP) != 4'd0) begin
      a_ctx_next.op.ymode  = 1'b1;
      a_ctx_next.op.edge_q = win.top;
    end else if ((co & OC_BOTTOM) != 4'd0) begin
      a_ctx_next.op.ymode  = 1'b1;
      a_ctx_next.op.edge_q = win.bottom;
    end else if ((co & OC_RIGHT) != 4'd0) begin
      a_ctx_next.op.ymode  = 1'b0;
      a_ctx_next.op.edge_q = win.right;
    end else begin
      a_ctx_next.op.ymode  = 1'b0;
      a_ctx_next.op.edge_q = win.left;
    end
    if (a_ctx_next.op.ymode) begin
      a_ctx_next.op.p0 = in_seg.x0;
      p1               = in_seg.x1;
      q0               = in_seg.y0;
      q1               = in_seg.y1;
    end else begin
      a_ctx_next.op.p0 = in_seg.y0;
      p1               = in_seg.y1;
      q0               = in_seg.x0;
      q1               = in_seg.x1;
    end
    dp = DIFF_W'(p1) - DIFF_W'(a_ctx_next.op.p0);
    dn = DIFF_W'(a_ctx_next.op.edge_q) - DIFF_W'(q0);
    dq = DIFF_W'(q1) - DIFF_W'(q0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
      b_vld <= a_vld;
    end
    if (en) begin
      a_ctx <= a_ctx_next;
      a_dp  <= dp;
      a_dn  <= dn;
      a_dq  <= dq;
      b_ctx <= a_ctx;
      b_num <= NUM_W'(a_dp) * NUM_W'(a_dn);
      b_dq  <= a_dq;
    end
  end

  lsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (b_vld),
    .in_ctx   (b_ctx),
    .in_num   (b_num),
    .in_dq    (b_dq),
    .out_vld  (d_vld),
    .out_ctx  (d_ctx),
    .out_quot (d_quot)
  );

  always_comb begin
    sum      = SUM_W'(d_ctx.op.p0) + SUM_W'(d_quot);
    v        = sat_coord(32'(sum));
    seg_next = d_ctx.seg;
    if (d_ctx.op.active) begin
      if (!d_ctx.op.sel_end) begin
        seg_next.x0 = d_ctx.op.ymode ? v : d_ctx.op.edge_q;
        seg_next.y0 = d_ctx.op.ymode ? d_ctx.op.edge_q : v;
        seg_next.c0 = outcode(seg_next.x0, seg_next.y0, win);
      end else begin
        seg_next.x1 = d_ctx.op.ymode ? v : d_ctx.op.edge_q;
        seg_next.y1 = d_ctx.op.ymode ? d_ctx.op.edge_q : v;
        seg_next.c1 = outcode(seg_next.x1, seg_next.y1, win);
      end
      seg_next.steps = d_ctx.seg.steps + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= d_vld;
    end
    if (en) begin
      out_seg <= seg_next;
    end
  end

endmodule
